// File: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent, outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent, outside reset.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Checked through reset as well.
`define ASSERT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/acpt_pkg.sv
package acpt_pkg;

  typedef enum logic [4:0] {
    S_IDLE,
    S_READ,
    S_LOAD,
    S_MV_OLD,
    S_MUL_FLOW,
    S_ADD_COMM,
    S_SUB_CASH,
    S_MUL_A,
    S_MUL_B,
    S_SUM,
    S_DIV_INIT,
    S_DIV,
    S_DIV_DONE,
    S_MUL_PNL,
    S_ADD_RZ,
    S_ADD_RSUM,
    S_MUL_U,
    S_MUL_MV,
    S_DIFF_U,
    S_ACC_U,
    S_DIFF_MV,
    S_ACC_MV,
    S_WRITE,
    S_CASH,
    S_EQUITY,
    S_FIN
  } st_t;

  typedef struct packed {
    logic signed [31:0] qty;
    logic [31:0]        avg;
    logic [31:0]        last;
    logic signed [63:0] rz;
    logic signed [63:0] uz;
  } row_t;

  localparam logic ACT_FILL = 1'b0;
  localparam logic ACT_PRICE = 1'b1;

  // Signed 64-bit add or subtract, clipped to the signed range.
  function automatic logic signed [63:0] sat_addsub(input logic signed [63:0] a,
                                                    input logic signed [63:0] b,
                                                    input logic sub);
    logic signed [64:0] s;
    if (sub) begin
      s = {a[63], a} - {b[63], b};
    end else begin
      s = {a[63], a} + {b[63], b};
    end
    if (s[64] != s[63]) begin
      sat_addsub = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sat_addsub = s[63:0];
    end
  endfunction

endpackage

// File: design/average_cost_position_tracker.sv
// Average-cost position tracker.
// Input channel: one transfer carries a fill (action 0) or a market price update
// (action 1) for one symbol. in_stall is high from the transfer until the item
// has been worked through; one item is in flight at a time.
// Output channel: one result per input item, held in an output register until
// the receiver takes it; a stalled result holds its value, and the next input
// may be taken while it waits. If a result is still waiting when the next one is
// ready, the sequencer holds in its last state until the register frees up.
// An index outside the table or a price update with no entry skips to the cash
// and equity steps; a price update marks to market; a fill on a flat position
// opens at the fill price; a reducing or flipping fill books realized profit; a
// fill adding to a position recomputes the average price. All products and
// saturating sums run through one shared 33 by 33 multiplier and one saturating
// 64-bit adder under a sequencer; the average price uses a radix-2 divider, one
// quotient bit per cycle for a 32-bit quotient. Configuration: the starting cash
// balance at byte address 0 of the 64-bit register port. The user must write it
// only while the block is idle; the block does not enforce this. pready is always
// high. Reset (rst, synchronous) clears the position table through one valid bit
// per entry, the running totals and the starting cash, and empties the output.
module average_cost_position_tracker #(
  parameter int SYMBOL_COUNT = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               action,
  input  logic [7:0]         symbol_index,
  input  logic               is_buy,
  input  logic [30:0]        quantity,
  input  logic [31:0]        price,
  input  logic [31:0]        commission,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               entry_exists,
  output logic signed [31:0] position_quantity,
  output logic [31:0]        mean_price,
  output logic signed [63:0] symbol_realized,
  output logic signed [63:0] symbol_unrealized,
  output logic signed [63:0] cash_balance,
  output logic signed [63:0] total_realized,
  output logic signed [63:0] unrealized_total,
  output logic signed [63:0] total_equity,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);
  import acpt_pkg::*;

  localparam int DEPTH = (SYMBOL_COUNT < 256) ? SYMBOL_COUNT : 256;
  localparam int AW = $clog2(DEPTH);

  st_t state, state_next;

  row_t pos_mem [DEPTH];
  row_t rd_row;
  logic [DEPTH-1:0] valid;

  // Captured item.
  logic               act;
  logic [7:0]         idx;
  logic               ok;
  logic signed [32:0] f;
  logic [30:0]        qty;
  logic [31:0]        px;
  logic [31:0]        comm;

  // Working copy of the entry.
  logic               vld;
  logic signed [31:0] q;
  logic [31:0]        ep;
  logic signed [63:0] rz;
  logic signed [63:0] uz;

  logic signed [63:0] old_mv, prod, acc, nu;
  logic signed [63:0] ncf, rsum, usum, mvsum, cash, init_cash;
  logic [63:0]        num;
  logic [31:0]        dvs, rem, quo;
  logic [4:0]         cnt;

  logic signed [32:0] mul_a, mul_b;
  logic signed [63:0] mul_y;
  logic signed [63:0] add_a, add_b, add_y;
  logic               add_sub;

  logic [AW-1:0]      addr;
  logic               accept, cfg_wr;
  logic [31:0]        mq;
  logic signed [32:0] diff, closed, qsum;
  logic [32:0]        trial;
  logic               take_bit;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign addr = idx[AW-1:0];
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == 4'd0);
  assign prdata = (paddr == 4'd0) ? init_cash : 64'd0;

  assign mq = q[31] ? 32'(-{q[31], q}) : 32'(q);
  assign diff = $signed({1'b0, px}) - $signed({1'b0, ep});
  assign closed = ({1'b0, mq} < {2'b00, qty}) ? 33'(q) : -f;
  assign qsum = 33'(q) + f;
  assign trial = {rem, num[63]};
  assign take_bit = (trial >= {1'b0, dvs});

  // Every product here fits in 64 bits, so no saturation is needed.
  assign mul_y = mul_a * mul_b;
  assign add_y = sat_addsub(add_a, add_b, add_sub);

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (accept) state_next = S_READ;
      S_READ:     state_next = S_LOAD;
      S_LOAD: begin
        if (!ok || (act == ACT_PRICE && !valid[addr])) begin
          state_next = S_CASH;
        end else begin
          state_next = S_MV_OLD;
        end
      end
      S_MV_OLD:   state_next = (act == ACT_PRICE) ? S_MUL_U : S_MUL_FLOW;
      S_MUL_FLOW: state_next = S_ADD_COMM;
      S_ADD_COMM: state_next = S_SUB_CASH;
      S_SUB_CASH: begin
        if (q == 32'sd0) begin
          state_next = S_MUL_U;
        end else if ((q > 0 && f > 0) || (q < 0 && f < 0)) begin
          state_next = S_MUL_A;
        end else begin
          state_next = S_MUL_PNL;
        end
      end
      S_MUL_A:    state_next = S_MUL_B;
      S_MUL_B:    state_next = S_SUM;
      S_SUM:      state_next = S_DIV_INIT;
      S_DIV_INIT: state_next = S_DIV;
      S_DIV:      if (cnt == 5'd0) state_next = S_DIV_DONE;
      S_DIV_DONE: state_next = S_MUL_U;
      S_MUL_PNL:  state_next = S_ADD_RZ;
      S_ADD_RZ:   state_next = S_ADD_RSUM;
      S_ADD_RSUM: state_next = S_MUL_U;
      S_MUL_U:    state_next = S_MUL_MV;
      S_MUL_MV:   state_next = S_DIFF_U;
      S_DIFF_U:   state_next = S_ACC_U;
      S_ACC_U:    state_next = S_DIFF_MV;
      S_DIFF_MV:  state_next = S_ACC_MV;
      S_ACC_MV:   state_next = S_WRITE;
      S_WRITE:    state_next = S_CASH;
      S_CASH:     state_next = S_EQUITY;
      S_EQUITY:   state_next = S_FIN;
      S_FIN:      if (!out_valid || !out_stall) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Operand selection for the shared multiplier and adder.
  always_comb begin
    mul_a = 33'sd0;
    mul_b = 33'sd0;
    add_a = 64'sd0;
    add_b = 64'sd0;
    add_sub = 1'b0;
    case (state)
      S_MV_OLD: begin
        // A stale or unwritten row must not leak into the old market value.
        mul_a = 33'(q);
        mul_b = vld ? $signed({1'b0, rd_row.last}) : 33'sd0;
      end
      S_MUL_FLOW: begin
        mul_a = f;
        mul_b = $signed({1'b0, px});
      end
      S_MUL_A: begin
        mul_a = $signed({1'b0, mq});
        mul_b = $signed({1'b0, ep});
      end
      S_MUL_B: begin
        mul_a = $signed({2'b00, qty});
        mul_b = $signed({1'b0, px});
      end
      S_MUL_PNL: begin
        mul_a = closed;
        mul_b = diff;
      end
      S_MUL_U: begin
        mul_a = 33'(q);
        mul_b = diff;
      end
      S_MUL_MV: begin
        mul_a = 33'(q);
        mul_b = $signed({1'b0, px});
      end
      S_ADD_COMM: begin
        add_a = prod;
        add_b = $signed({32'd0, comm});
      end
      S_SUB_CASH: begin
        add_a = ncf;
        add_b = acc;
        add_sub = 1'b1;
      end
      S_ADD_RZ: begin
        add_a = rz;
        add_b = prod;
      end
      S_ADD_RSUM: begin
        add_a = rsum;
        add_b = prod;
      end
      S_DIFF_U: begin
        add_a = nu;
        add_b = uz;
        add_sub = 1'b1;
      end
      S_ACC_U: begin
        add_a = usum;
        add_b = acc;
      end
      S_DIFF_MV: begin
        add_a = prod;
        add_b = old_mv;
        add_sub = 1'b1;
      end
      S_ACC_MV: begin
        add_a = mvsum;
        add_b = acc;
      end
      S_CASH: begin
        add_a = init_cash;
        add_b = ncf;
      end
      S_EQUITY: begin
        add_a = cash;
        add_b = mvsum;
      end
      default: begin
        add_sub = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Position table: registered read, at most one write per item.
  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      rd_row <= pos_mem[addr];
    end
    if (state == S_WRITE) begin
      pos_mem[addr] <= '{qty: q, avg: ep, last: px, rz: rz, uz: uz};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (state == S_WRITE) begin
      valid[addr] <= 1'b1;
    end
  end

  // Running totals and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      ncf <= '0;
      rsum <= '0;
      usum <= '0;
      mvsum <= '0;
      init_cash <= '0;
    end else begin
      if (cfg_wr) init_cash <= pwdata;
      case (state)
        S_SUB_CASH: ncf <= add_y;
        S_ADD_RSUM: rsum <= add_y;
        S_ACC_U:    usum <= add_y;
        S_ACC_MV:   mvsum <= add_y;
        default:    ;
      endcase
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          act <= action;
          idx <= symbol_index;
          ok <= (32'(symbol_index) < 32'(SYMBOL_COUNT));
          f <= is_buy ? $signed({2'b00, quantity}) : -$signed({2'b00, quantity});
          qty <= quantity;
          px <= price;
          comm <= commission;
        end
      end
      S_LOAD: begin
        // An entry never written reads as all zero.
        vld <= ok && valid[addr];
        q <= (ok && valid[addr]) ? rd_row.qty : 32'sd0;
        ep <= (ok && valid[addr]) ? rd_row.avg : 32'd0;
        rz <= (ok && valid[addr]) ? rd_row.rz : 64'sd0;
        uz <= (ok && valid[addr]) ? rd_row.uz : 64'sd0;
      end
      S_MV_OLD:   old_mv <= mul_y;
      S_MUL_FLOW: prod <= mul_y;
      S_ADD_COMM: acc <= add_y;
      S_SUB_CASH: begin
        if (q == 32'sd0) begin
          q <= f[31:0];
          ep <= px;
        end
      end
      S_MUL_A:    acc <= mul_y;
      S_MUL_B:    prod <= mul_y;
      S_SUM: begin
        num <= acc + prod;
        dvs <= mq + {1'b0, qty};
      end
      S_DIV_INIT: begin
        rem <= num[63:32];
        num <= {num[31:0], 32'd0};
        cnt <= 5'd31;
        quo <= '0;
      end
      S_DIV: begin
        rem <= take_bit ? 32'(trial - {1'b0, dvs}) : trial[31:0];
        quo <= {quo[30:0], take_bit};
        num <= {num[62:0], 1'b0};
        cnt <= cnt - 5'd1;
      end
      S_DIV_DONE: begin
        ep <= quo;
        if (qsum > 33'sd2147483647) begin
          q <= 32'sh7fffffff;
        end else if (qsum < -33'sd2147483648) begin
          q <= 32'sh80000000;
        end else begin
          q <= qsum[31:0];
        end
      end
      S_MUL_PNL:  prod <= mul_y;
      S_ADD_RZ:   rz <= add_y;
      S_ADD_RSUM: begin
        q <= qsum[31:0];
        if (qsum == 33'sd0) begin
          ep <= 32'd0;
        end else if (qsum[32] != q[31]) begin
          ep <= px;
        end
      end
      S_MUL_U:    nu <= mul_y;
      S_MUL_MV:   prod <= mul_y;
      S_DIFF_U:   acc <= add_y;
      S_ACC_U:    uz <= nu;
      S_DIFF_MV:  acc <= add_y;
      S_WRITE:    vld <= 1'b1;
      S_CASH:     cash <= add_y;
      S_EQUITY:   acc <= add_y;
      default:    ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && (!out_valid || !out_stall)) begin
      entry_exists <= vld;
      position_quantity <= q;
      mean_price <= ep;
      symbol_realized <= rz;
      symbol_unrealized <= uz;
      cash_balance <= cash;
      total_realized <= rsum;
      unrealized_total <= usum;
      total_equity <= acc;
    end
  end

endmodule

// File: design/acpt_checker.sv
`include "assert_macros.svh"

module acpt_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               entry_exists,
  input logic signed [31:0] position_quantity,
  input logic [31:0]        mean_price
);

  // The block works on one item at a time.
  `ASSERT_NEXT(a_busy_after_transfer, clk, rst, in_valid && !in_stall, in_stall, "busy flag low")

  // A waiting result is not dropped.
  `ASSERT_NEXT(a_result_held, clk, rst, out_valid && out_stall, out_valid, "result dropped")

  // A symbol without an entry reports a flat, zero-priced position.
  `ASSERT_SAME(a_absent_is_flat, clk, rst, out_valid && !entry_exists,
               position_quantity == 32'sd0 && mean_price == 32'd0, "absent entry not zero")

  // Reset empties the output and leaves the block ready.
  `ASSERT_ALWAYS(a_reset_clears, clk, rst, !out_valid && !in_stall, "reset state wrong")

endmodule

bind average_cost_position_tracker acpt_checker u_acpt_checker (.*);

// File: verif/tb_average_cost_position_tracker.sv
`timescale 1ns / 1ps

module tb_average_cost_position_tracker;
  import acpt_pkg::*;

  localparam int TABLE_SIZE = 256;
  localparam int DRAIN_CYCLES = 80;
  localparam longint CYCLE_LIMIT = 1000000;
  localparam longint S64_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam longint S64_MIN = 64'sh8000_0000_0000_0000;

  typedef struct {
    logic        action;
    logic [7:0]  symbol_index;
    logic        is_buy;
    logic [30:0] quantity;
    logic [31:0] price;
    logic [31:0] commission;
  } order_t;

  typedef struct {
    logic        entry_exists;
    logic [31:0] position_quantity;
    logic [31:0] mean_price;
    logic [63:0] symbol_realized;
    logic [63:0] symbol_unrealized;
    logic [63:0] cash_balance;
    logic [63:0] total_realized;
    logic [63:0] unrealized_total;
    logic [63:0] total_equity;
  } snapshot_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic action = 1'b0;
  logic [7:0] symbol_index = '0;
  logic is_buy = 1'b0;
  logic [30:0] quantity = '0;
  logic [31:0] price = '0;
  logic [31:0] commission = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic entry_exists;
  logic signed [31:0] position_quantity;
  logic [31:0] mean_price;
  logic signed [63:0] symbol_realized, symbol_unrealized, cash_balance;
  logic signed [63:0] total_realized, unrealized_total, total_equity;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  average_cost_position_tracker dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow of the position book.
  bit     book_open [TABLE_SIZE];
  longint book_qty [TABLE_SIZE];
  bit [31:0] book_avg [TABLE_SIZE];
  bit [31:0] book_last [TABLE_SIZE];
  longint book_rz [TABLE_SIZE];
  longint book_uz [TABLE_SIZE];
  longint cash_flow, rz_sum, uz_sum, mv_sum, start_cash;

  order_t    order_queue[$];
  snapshot_t snapshot_queue[$];
  int errors = 0;
  bit quiet = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  longint cycles = 0;

  function automatic longint clip_add(longint a, longint b);
    logic signed [64:0] s;
    s = a;
    s = s + b;
    if (s > S64_MAX) return S64_MAX;
    if (s < S64_MIN) return S64_MIN;
    return s[63:0];
  endfunction

  function automatic longint clip_sub(longint a, longint b);
    logic signed [64:0] s;
    s = a;
    s = s - b;
    if (s > S64_MAX) return S64_MAX;
    if (s < S64_MIN) return S64_MIN;
    return s[63:0];
  endfunction

  function automatic longint clip_mul(longint a, longint b);
    logic signed [127:0] wa, wb, p;
    wa = a;
    wb = b;
    p = wa * wb;
    if (p > S64_MAX) return S64_MAX;
    if (p < S64_MIN) return S64_MIN;
    return p[63:0];
  endfunction

  function automatic void mark_to_market(int s, bit [31:0] px, longint old_mv);
    longint new_u, new_mv;
    new_u = clip_mul(book_qty[s], longint'(px) - longint'(book_avg[s]));
    new_mv = clip_mul(book_qty[s], longint'(px));
    uz_sum = clip_add(uz_sum, clip_sub(new_u, book_uz[s]));
    mv_sum = clip_add(mv_sum, clip_sub(new_mv, old_mv));
    book_uz[s] = new_u;
    book_last[s] = px;
  endfunction

  function automatic snapshot_t apply_order(order_t o);
    int s;
    longint f, q, old_mv, flow, closed, pnl, rem, cash;
    logic [64:0] mq, mf, num;
    snapshot_t r;
    s = int'(o.symbol_index);
    if (o.action == ACT_FILL) begin
      f = o.is_buy ? longint'(o.quantity) : -longint'(o.quantity);
      q = book_qty[s];
      old_mv = clip_mul(q, longint'(book_last[s]));
      flow = clip_add(clip_mul(f, longint'(o.price)), longint'(o.commission));
      cash_flow = clip_sub(cash_flow, flow);
      book_open[s] = 1'b1;
      if (q == 0) begin
        book_qty[s] = f;
        book_avg[s] = o.price;
      end else if ((q > 0 && f > 0) || (q < 0 && f < 0)) begin
        mq = (q < 0) ? -q : q;
        mf = (f < 0) ? -f : f;
        num = mq * book_avg[s] + mf * o.price;
        num = num / (mq + mf);
        book_avg[s] = num[31:0];
        rem = q + f;
        if (rem > 64'sd2147483647) rem = 64'sd2147483647;
        if (rem < -64'sd2147483648) rem = -64'sd2147483648;
        book_qty[s] = rem;
      end else begin
        mq = (q < 0) ? -q : q;
        mf = (f < 0) ? -f : f;
        closed = (mq < mf) ? q : -f;
        pnl = clip_mul(closed, longint'(o.price) - longint'(book_avg[s]));
        rem = q + f;
        book_rz[s] = clip_add(book_rz[s], pnl);
        rz_sum = clip_add(rz_sum, pnl);
        book_qty[s] = rem;
        if (rem == 0) book_avg[s] = 32'd0;
        else if ((q > 0) != (rem > 0)) book_avg[s] = o.price;
      end
      mark_to_market(s, o.price, old_mv);
    end else if (book_open[s]) begin
      mark_to_market(s, o.price, clip_mul(book_qty[s], longint'(book_last[s])));
    end
    cash = clip_add(start_cash, cash_flow);
    r.entry_exists = book_open[s];
    r.position_quantity = book_qty[s][31:0];
    r.mean_price = book_avg[s];
    r.symbol_realized = book_rz[s];
    r.symbol_unrealized = book_uz[s];
    r.cash_balance = cash;
    r.total_realized = rz_sum;
    r.unrealized_total = uz_sum;
    r.total_equity = clip_add(cash, mv_sum);
    return r;
  endfunction

  function automatic int idle_draw();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: the book is updated at the edge on which the transfer happens.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        snapshot_queue.push_back(apply_order('{action, symbol_index, is_buy, quantity,
                                                price, commission}));
        gap_left = idle_draw();
      end
      if (in_valid && in_stall) begin
        // hold the payload
      end else if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (order_queue.size() > 0) begin
        order_t o;
        o = order_queue.pop_front();
        action <= o.action;
        symbol_index <= o.symbol_index;
        is_buy <= o.is_buy;
        quantity <= o.quantity;
        price <= o.price;
        commission <= o.commission;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Monitor.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (snapshot_queue.size() == 0) begin
          $display("%0t: result with nothing outstanding", $time);
          errors++;
        end else begin
          snapshot_t w;
          w = snapshot_queue.pop_front();
          check_field("entry_exists", w.entry_exists, entry_exists);
          check_field("position_quantity", w.position_quantity,
                      $unsigned(position_quantity));
          check_field("mean_price", w.mean_price, mean_price);
          check_field("symbol_realized", w.symbol_realized, symbol_realized);
          check_field("symbol_unrealized", w.symbol_unrealized, symbol_unrealized);
          check_field("cash_balance", w.cash_balance, cash_balance);
          check_field("total_realized", w.total_realized, total_realized);
          check_field("unrealized_total", w.unrealized_total, unrealized_total);
          check_field("total_equity", w.total_equity, total_equity);
        end
      end
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_stall <= 1'b1;
      end else begin
        stall_left = idle_draw();
        out_stall <= (stall_left > 0);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_average_cost_position_tracker: done, errors");
      $finish;
    end
  end

  function automatic order_t make_order(bit act, int sym, bit buy, int unsigned qty,
                                        int unsigned px, int unsigned comm);
    order_t o;
    o.action = act;
    o.symbol_index = 8'(sym);
    o.is_buy = buy;
    o.quantity = 31'(qty);
    o.price = px;
    o.commission = comm;
    return o;
  endfunction

  function automatic order_t random_order();
    order_t o;
    int roll;
    roll = $urandom_range(0, 99);
    o.action = (roll < 75) ? ACT_FILL : ACT_PRICE;
    o.symbol_index = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(0, 7));
    o.is_buy = 1'($urandom_range(0, 1));
    roll = $urandom_range(0, 99);
    if (roll < 60) o.quantity = 31'($urandom_range(0, 1000));
    else if (roll < 85) o.quantity = 31'($urandom_range(0, 1 << 20));
    else o.quantity = 31'($urandom);
    if ($urandom_range(0, 9) < 7) o.price = 32'h0064_0000 + $urandom_range(0, 32'h0020_0000)
                                            - 32'h0010_0000;
    else o.price = $urandom;
    o.commission = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 32'h0005_0000);
    return o;
  endfunction

  task automatic write_start_cash(logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= '0;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    start_cash = value;
  endtask

  // Sampled away from the rising edge so that queue and valid updates have settled.
  task automatic settle();
    while (order_queue.size() > 0 || in_valid || snapshot_queue.size() > 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [63:0] cash_settings [4];
    cash_settings[0] = S64_MAX;
    cash_settings[1] = S64_MIN;
    cash_settings[2] = {$urandom, $urandom};
    cash_settings[3] = 64'd0;
    start_cash = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 4; ph++) begin
      quiet = (ph == 3);
      write_start_cash(cash_settings[ph]);
      if (ph == 0) begin
        // A price update for a symbol with no entry, then a zero fill on a flat one.
        order_queue.push_back(make_order(ACT_PRICE, 200, 0, 0, 32'h0001_0000, 0));
        order_queue.push_back(make_order(ACT_FILL, 1, 1, 0, 32'h0010_0000, 32'h0000_8000));
        order_queue.push_back(make_order(ACT_FILL, 1, 1, 0, 32'h0011_0000, 5));
        order_queue.push_back(make_order(ACT_FILL, 1, 1, 100, 32'h0010_0000, 0));
        order_queue.push_back(make_order(ACT_FILL, 1, 1, 0, 32'h0012_0000, 7));
        order_queue.push_back(make_order(ACT_FILL, 1, 1, 50, 32'h0013_0003, 1));
        order_queue.push_back(make_order(ACT_FILL, 1, 0, 30, 32'h0015_0000, 2));
        order_queue.push_back(make_order(ACT_PRICE, 1, 1, 77, 32'h0009_0000, 99));
        order_queue.push_back(make_order(ACT_FILL, 1, 0, 120, 32'h0014_0000, 0));
        order_queue.push_back(make_order(ACT_FILL, 1, 0, 40, 32'h0012_0000, 0));
        order_queue.push_back(make_order(ACT_FILL, 1, 1, 100, 32'h0011_0000, 0));
        order_queue.push_back(make_order(ACT_FILL, 1, 1, 25, 32'h0010_0000, 0));
        order_queue.push_back(make_order(ACT_FILL, 255, 1, 31'h7fff_ffff, 32'hffff_ffff,
                                         32'hffff_ffff));
        order_queue.push_back(make_order(ACT_FILL, 255, 1, 31'h7fff_ffff, 32'hffff_ffff,
                                         32'hffff_ffff));
        order_queue.push_back(make_order(ACT_PRICE, 255, 0, 0, 32'h0000_0000, 0));
        order_queue.push_back(make_order(ACT_PRICE, 255, 0, 0, 32'hffff_ffff, 0));
        order_queue.push_back(make_order(ACT_FILL, 255, 0, 31'h7fff_ffff, 0, 32'hffff_ffff));
        order_queue.push_back(make_order(ACT_FILL, 0, 0, 31'h7fff_ffff, 32'hffff_ffff, 0));
        order_queue.push_back(make_order(ACT_FILL, 0, 0, 31'h7fff_ffff, 32'hffff_ffff, 0));
        order_queue.push_back(make_order(ACT_FILL, 0, 1, 31'h7fff_ffff, 0, 0));
        order_queue.push_back(make_order(ACT_PRICE, 0, 1, 0, 32'h8000_0000, 0));
      end
      for (int n = 0; n < 300; n++) order_queue.push_back(random_order());
      settle();
    end
    if (errors == 0) begin
      $display("tb_average_cost_position_tracker: done, clean");
    end else begin
      $display("tb_average_cost_position_tracker: done, errors");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/acpt_pkg.sv
design/average_cost_position_tracker.sv
design/acpt_checker.sv
verif/tb_average_cost_position_tracker.sv
